>>> design/bvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bvr_pkg;

  localparam logic [2:0] MODE_READ      = 3'd0;
  localparam logic [2:0] MODE_WRITE     = 3'd1;
  localparam logic [2:0] MODE_BANK_CTRL = 3'd2;
  localparam logic [2:0] MODE_ROM_SEL   = 3'd3;
  localparam logic [2:0] MODE_BANK_SW   = 3'd4;

  localparam logic [7:0] BC_VRAM    = 8'h00;
  localparam logic [7:0] BC_SCRATCH = 8'h02;
  localparam logic [7:0] BC_SELECT  = 8'h03;

  localparam logic [7:0] SELECT_MASK  = 8'hfe;
  localparam logic [7:0] ROM_SEL_MASK = 8'h7f;
  localparam logic [7:0] PROG_MASK    = 8'h0f;
  localparam int unsigned FILL_BIT    = 6;
  localparam int unsigned PMC_BIT     = 7;
  localparam int unsigned ROM_SHIFT   = 12;

  typedef struct packed {
    logic [2:0]  mode;
    logic [12:0] offset;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_read;
    logic [18:0] rom_address;
    logic [3:0]  program_bank;
  } result_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_cmd_t;

endpackage

`default_nettype wire

>>> design/bvr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bvr_ram #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire bvr_pkg::mem_cmd_t        cmd_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [7:0]               wdata_i,
  output logic      [7:0]               rdata_o
);
  import bvr_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.en && cmd_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (cmd_i.en && !cmd_i.we) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/banked_video_ram_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      req_i  (bvr_pkg::item_t)
// result    out        done_o, one cycle         rsp_o  (bvr_pkg::result_t)
//
// An accepted item is held in item_q; its result is registered in ST_EXEC, or in
// ST_RDATA when it reads a video bank or scratch RAM via the registered memory port.
// A filling bank switch reads the fill bank and byte from scratch entries 0 and 1,
// then writes BANK_BYTES entries, one write per cycle. After reset the memories are
// cleared one entry per cycle up to max(BANK_BYTES, SCRATCH_BYTES) with busy high.
// A new item may be accepted in the cycle its predecessor's result is shown.
// The receiver cannot stall; each result is valid only while done_o is high.

module banked_video_ram_controller #(
  parameter int unsigned BANK_BYTES    = 8192,
  parameter int unsigned SCRATCH_BYTES = 2048,
  parameter int unsigned ROM_WINDOW    = 4096
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire bvr_pkg::item_t  req_i,
  output logic                 done_o,
  output bvr_pkg::result_t     rsp_o
);
  import bvr_pkg::*;

  localparam int unsigned BANK_AW = $clog2(BANK_BYTES);
  localparam int unsigned SCR_AW  = $clog2(SCRATCH_BYTES);
  localparam int unsigned CLR_N   =
      (BANK_BYTES > SCRATCH_BYTES) ? BANK_BYTES : SCRATCH_BYTES;
  localparam int unsigned CNT_W   = $clog2(CLR_N);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SC0,
    ST_SC1,
    ST_FILL
  } state_e;

  state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  item_t       item_q, item_d;
  result_t     rsp_q, rsp_d;
  logic        done_q, done_d;
  logic [7:0]  bank_control_q, bank_control_d;
  logic [7:0]  rom_select_q, rom_select_d;
  logic        selected_bank_q, selected_bank_d;
  logic        pmc_q, pmc_d;
  logic [3:0]  program_bank_q, program_bank_d;
  logic        fill_bank_q, fill_bank_d;
  logic [7:0]  fill_byte_q, fill_byte_d;

  mem_cmd_t           v0_cmd, v1_cmd, sc_cmd;
  logic [BANK_AW-1:0] v0_addr, v1_addr;
  logic [SCR_AW-1:0]  sc_addr;
  logic [7:0]         v0_wdata, v1_wdata, sc_wdata;
  logic [7:0]         v0_rdata, v1_rdata, sc_rdata;

  logic rom_hit, in_bank, in_scr, sel_wr, vram_rd, scr_rd;
  logic bank_clr, scr_clr;
  logic [7:0] rd_byte;
  logic [18:0] rom_addr;

  assign rom_hit  = (rom_select_q != 8'd0) && (32'(item_q.offset) < 32'(ROM_WINDOW));
  assign in_bank  = 32'(item_q.offset) < 32'(BANK_BYTES);
  assign in_scr   = 32'(item_q.offset) < 32'(SCRATCH_BYTES);
  assign sel_wr   = (bank_control_q == BC_SELECT) && (item_q.offset == 13'd0)
                    && ((item_q.data & SELECT_MASK) == 8'd0);
  assign vram_rd  = !rom_hit && (bank_control_q == BC_VRAM) && in_bank;
  assign scr_rd   = !rom_hit && (bank_control_q == BC_SCRATCH) && in_scr;
  assign bank_clr = 32'(cnt_q) < 32'(BANK_BYTES);
  assign scr_clr  = 32'(cnt_q) < 32'(SCRATCH_BYTES);
  assign rom_addr = 19'({rom_select_q[6:0] & ROM_SEL_MASK[6:0], 12'd0})
                    + 19'(item_q.offset);
  assign rd_byte  = (bank_control_q == BC_VRAM)
                    ? (selected_bank_q ? v1_rdata : v0_rdata) : sc_rdata;

  always_comb begin
    v0_cmd   = '0;
    v1_cmd   = '0;
    sc_cmd   = '0;
    v0_addr  = BANK_AW'(item_q.offset);
    v1_addr  = BANK_AW'(item_q.offset);
    sc_addr  = SCR_AW'(item_q.offset);
    v0_wdata = item_q.data;
    v1_wdata = item_q.data;
    sc_wdata = item_q.data;
    unique case (state_q)
      ST_CLEAR: begin
        v0_addr   = BANK_AW'(cnt_q);
        v1_addr   = BANK_AW'(cnt_q);
        sc_addr   = SCR_AW'(cnt_q);
        v0_wdata  = 8'd0;
        v1_wdata  = 8'd0;
        sc_wdata  = 8'd0;
        v0_cmd.en = bank_clr;
        v0_cmd.we = bank_clr;
        v1_cmd.en = bank_clr;
        v1_cmd.we = bank_clr;
        sc_cmd.en = scr_clr;
        sc_cmd.we = scr_clr;
      end
      ST_EXEC: begin
        unique case (item_q.mode)
          MODE_READ: begin
            if (vram_rd) begin
              v0_cmd.en = !selected_bank_q;
              v1_cmd.en = selected_bank_q;
            end else if (scr_rd) begin
              sc_cmd.en = 1'b1;
            end
          end
          MODE_WRITE: begin
            if (sel_wr) begin
              sc_cmd = '0;
            end else if (bank_control_q == BC_VRAM) begin
              if (pmc_q && in_bank) begin
                v0_cmd.en = !selected_bank_q;
                v0_cmd.we = !selected_bank_q;
                v1_cmd.en = selected_bank_q;
                v1_cmd.we = selected_bank_q;
              end
            end else if (bank_control_q == BC_SCRATCH && in_scr) begin
              sc_cmd.en = pmc_q;
              sc_cmd.we = pmc_q;
            end
          end
          MODE_BANK_SW: begin
            sc_addr   = '0;
            sc_cmd.en = item_q.data[FILL_BIT];
          end
          default: begin
            sc_cmd = '0;
          end
        endcase
      end
      ST_SC0: begin
        sc_addr   = SCR_AW'(1);
        sc_cmd.en = 1'b1;
      end
      ST_FILL: begin
        v0_addr   = BANK_AW'(cnt_q);
        v1_addr   = BANK_AW'(cnt_q);
        v0_wdata  = fill_byte_q;
        v1_wdata  = fill_byte_q;
        v0_cmd.en = !fill_bank_q;
        v0_cmd.we = !fill_bank_q;
        v1_cmd.en = fill_bank_q;
        v1_cmd.we = fill_bank_q;
      end
      default: begin
        sc_cmd = '0;
      end
    endcase
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    item_d          = item_q;
    rsp_d           = rsp_q;
    done_d          = 1'b0;
    bank_control_d  = bank_control_q;
    rom_select_d    = rom_select_q;
    selected_bank_d = selected_bank_q;
    pmc_d           = pmc_q;
    program_bank_d  = program_bank_q;
    fill_bank_d     = fill_bank_q;
    fill_byte_d     = fill_byte_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CNT_W'(CLR_N - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          item_d  = req_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rsp_d              = '0;
        rsp_d.program_bank = program_bank_q;
        done_d             = 1'b1;
        state_d            = ST_IDLE;
        unique case (item_q.mode)
          MODE_READ: begin
            if (rom_hit) begin
              rsp_d.rom_read    = 1'b1;
              rsp_d.rom_address = rom_addr;
            end else if (vram_rd || scr_rd) begin
              done_d  = 1'b0;
              state_d = ST_RDATA;
            end
          end
          MODE_WRITE: begin
            if (sel_wr) begin
              selected_bank_d = item_q.data[0];
            end
          end
          MODE_BANK_CTRL: begin
            bank_control_d = item_q.data;
          end
          MODE_ROM_SEL: begin
            rom_select_d = item_q.data;
          end
          MODE_BANK_SW: begin
            program_bank_d     = item_q.data[3:0] & PROG_MASK[3:0];
            rsp_d.program_bank = item_q.data[3:0] & PROG_MASK[3:0];
            pmc_d              = item_q.data[PMC_BIT];
            if (item_q.data[FILL_BIT]) begin
              done_d  = 1'b0;
              state_d = ST_SC0;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_RDATA: begin
        rsp_d.read_data = rd_byte;
        done_d          = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SC0: begin
        fill_bank_d = sc_rdata[0];
        state_d     = ST_SC1;
      end
      ST_SC1: begin
        fill_byte_d = sc_rdata;
        cnt_d       = '0;
        state_d     = ST_FILL;
      end
      ST_FILL: begin
        if (cnt_q == CNT_W'(BANK_BYTES - 1)) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      cnt_q           <= '0;
      item_q          <= '0;
      rsp_q           <= '0;
      done_q          <= 1'b0;
      bank_control_q  <= '0;
      rom_select_q    <= '0;
      selected_bank_q <= 1'b0;
      pmc_q           <= 1'b0;
      program_bank_q  <= '0;
      fill_bank_q     <= 1'b0;
      fill_byte_q     <= '0;
    end else begin
      state_q         <= state_d;
      cnt_q           <= cnt_d;
      item_q          <= item_d;
      rsp_q           <= rsp_d;
      done_q          <= done_d;
      bank_control_q  <= bank_control_d;
      rom_select_q    <= rom_select_d;
      selected_bank_q <= selected_bank_d;
      pmc_q           <= pmc_d;
      program_bank_q  <= program_bank_d;
      fill_bank_q     <= fill_bank_d;
      fill_byte_q     <= fill_byte_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  bvr_ram #(.DEPTH(BANK_BYTES)) u_vram0 (
    .clk_i   (clk_i),
    .cmd_i   (v0_cmd),
    .addr_i  (v0_addr),
    .wdata_i (v0_wdata),
    .rdata_o (v0_rdata)
  );

  bvr_ram #(.DEPTH(BANK_BYTES)) u_vram1 (
    .clk_i   (clk_i),
    .cmd_i   (v1_cmd),
    .addr_i  (v1_addr),
    .wdata_i (v1_wdata),
    .rdata_o (v1_rdata)
  );

  bvr_ram #(.DEPTH(SCRATCH_BYTES)) u_scratch (
    .clk_i   (clk_i),
    .cmd_i   (sc_cmd),
    .addr_i  (sc_addr),
    .wdata_i (sc_wdata),
    .rdata_o (sc_rdata)
  );

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe lasted more than one cycle.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted item did not make the block busy.");

  a_rom_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.rom_read) |-> (rsp_o.rom_address == 19'd0))
    else $error("ROM address given without a ROM request.");

  a_rom_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.rom_read) |-> (rsp_o.read_data == 8'd0))
    else $error("ROM request carried read data.");

  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |-> !(v0_cmd.we && v1_cmd.we))
    else $error("Both video banks written outside the clearing pass.");

endmodule

`default_nettype wire
